/* rtl/wildcard_byte_pattern_scan_macros.svh */
// ---------------------------------------------------------------------------
// wildcard byte pattern scan assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

`ifndef SYNTHESIS
// property checked on the rising edge, held off while reset is low
`define WBPS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, on the block's own clock and reset
`define WBPS_ASSERT(label, prop, msg) \
    `WBPS_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define WBPS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define WBPS_ASSERT(label, prop, msg)
`endif

`endif

/* rtl/wbps_pkg.sv */
// ---------------------------------------------------------------------------
// wildcard byte pattern scan package
// shared types and constants for the scan cells and the match accumulator
// ---------------------------------------------------------------------------
package wbps_pkg;

    // request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SCAN = 1'b1;

    // register select, byte address bit 3
    localparam logic REG_LEN  = 1'b0;
    localparam logic REG_BASE = 1'b1;

    localparam int unsigned LEN_W   = 9;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // broadcast to every cell
    typedef struct packed {
        logic             scan;
        logic             load;
        logic             last;
        logic [7:0]       idx;
        logic [7:0]       value;
        logic             wild;
        logic [LEN_W-1:0] len;
    } t_cell_ctl;

    // one scanned byte after the cell row
    typedef struct packed {
        logic              valid;
        logic              tail;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_s1;

endpackage

/* rtl/wbps_cell.sv */
// ---------------------------------------------------------------------------
// wbps scan cell
// one pattern entry and its partial match bit, chained to the next cell
// ---------------------------------------------------------------------------
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_pm,
    output logic      o_pm,
    output logic      o_tail
);

    logic [8:0] r_entry;   // bit 8 wildcard, bits 7..0 byte
    logic       r_pm;
    logic       w_active;
    logic       w_hit;
    logic       n_pm;

    assign w_active = 32'(i_ctl.len) > CELL_IDX;
    assign w_hit    = r_entry[8] || (r_entry[7:0] == i_ctl.value);
    assign n_pm     = w_active && i_prev_pm && w_hit;
    assign o_tail   = n_pm && (32'(i_ctl.len) == CELL_IDX + 1);
    assign o_pm     = r_pm;

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (32'(i_ctl.idx) == CELL_IDX)) begin
            r_entry <= {i_ctl.wild, i_ctl.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm <= 1'b0;
        end else if (i_ctl.scan) begin
            r_pm <= i_ctl.last ? 1'b0 : n_pm;
        end
    end

endmodule

/* rtl/wbps_accum.sv */
// ---------------------------------------------------------------------------
// wbps match accumulator
// counts matches, keeps the latest start address, holds the region result
// ---------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_macros.svh"

module wbps_accum
    import wbps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_s1                i_s1,
    input  logic               i_m_ready,
    output logic               o_free,
    output logic               o_m_valid,
    output logic [COUNT_W-1:0] o_count,
    output logic [ADDR_W-1:0]  o_found,
    output logic               o_unique
);

    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]  r_last_addr;
    logic               r_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [ADDR_W-1:0]  r_out_addr;
    logic               r_out_unique;
    logic               w_take;
    logic               w_report;
    logic [COUNT_W-1:0] n_count;
    logic [ADDR_W-1:0]  n_last_addr;

    assign o_free   = !r_valid || i_m_ready;
    assign w_take   = o_free && i_s1.valid;
    assign w_report = w_take && i_s1.last;

    // saturating count
    assign n_count     = (i_s1.tail && (r_count != COUNT_MAX)) ? r_count + COUNT_ONE : r_count;
    assign n_last_addr = i_s1.tail ? i_s1.addr : r_last_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_last_addr <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (w_take) begin
                if (i_s1.last) begin
                    r_count     <= '0;
                    r_last_addr <= '0;
                end else begin
                    r_count     <= n_count;
                    r_last_addr <= n_last_addr;
                end
            end
            if (o_free) begin
                r_valid <= w_report;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_report) begin
            r_out_count  <= n_count;
            r_out_addr   <= (n_count == COUNT_ONE) ? n_last_addr : '0;
            r_out_unique <= (n_count == COUNT_ONE);
        end
    end

    assign o_m_valid = r_valid;
    assign o_count   = r_out_count;
    assign o_found   = r_out_addr;
    assign o_unique  = r_out_unique;

    `WBPS_ASSERT(a_unique_count, r_valid |-> (r_out_unique == (r_out_count == COUNT_ONE)), "unique flag disagrees with count")
    `WBPS_ASSERT(a_addr_zero, (r_valid && !r_out_unique) |-> (r_out_addr == '0), "address reported without a single match")
    `WBPS_ASSERT(a_count_mono, !w_report |=> (r_count >= $past(r_count)), "match count fell within a region")

endmodule

/* rtl/wildcard_byte_pattern_scan.sv */
// ---------------------------------------------------------------------------
// wildcard byte pattern scan
// streams region bytes through a row of pattern cells and reports matches
// ---------------------------------------------------------------------------
// throughput: one transaction per cycle while the result slot is free, loads and
// scan bytes alike, set by the cell row; the result of a region's final byte goes
// through the cell row and tail select, then the accumulator and its output register
// reset: synchronous, active low; clears partial matches, offset, count, address
// and registers; pattern entries are not cleared and need no clearing pass
// ---------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_macros.svh"

module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // apb configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // pattern_index, value, wildcard_req, zero pad
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,   // req_type
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // match_count, found_address, unique_res, zero pad
);

    // configuration registers
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_base;
    logic              w_cfg_wr;

    // stream side
    logic              w_free;
    logic              w_acc;
    logic              w_scan_acc;
    logic              w_load_acc;
    logic [LEN_W-1:0]  w_len_c;       // length held to the cell count
    logic [ADDR_W-1:0] r_offset;
    t_cell_ctl         w_ctl;
    logic [MAX_PATTERN-1:0] w_pm;
    logic [MAX_PATTERN-1:0] w_tail;
    t_s1               r_s1;

    // result side
    logic [COUNT_W-1:0] w_count;
    logic [ADDR_W-1:0]  w_found;
    logic               w_unique;

    // -----------------------------------------------------------------------
    // apb port: bit 3 of the byte address selects the register
    // -----------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_base <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3])
                REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                REG_BASE: r_base <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_LEN:  prdata = 64'(r_len);
            REG_BASE: prdata = r_base;
            default:  prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // input handshake; the whole row advances only when the result slot is free
    // -----------------------------------------------------------------------
    assign s_axis_tready = w_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_scan_acc    = w_acc && (s_axis_tuser == REQ_SCAN);
    assign w_load_acc    = w_acc && (s_axis_tuser == REQ_LOAD);

    // a length above the cell count acts as the full row
    assign w_len_c = (32'(r_len) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : r_len;

    assign w_ctl.scan  = w_scan_acc;
    assign w_ctl.load  = w_load_acc;
    assign w_ctl.last  = s_axis_tlast;
    assign w_ctl.idx   = s_axis_tdata[7:0];
    assign w_ctl.value = s_axis_tdata[15:8];
    assign w_ctl.wild  = s_axis_tdata[16];
    assign w_ctl.len   = w_len_c;

    // -----------------------------------------------------------------------
    // cell row: cell i holds pattern entry i and whether the last i+1 bytes
    // matched entries 0..i; each cell takes its left neighbour's bit per byte
    // -----------------------------------------------------------------------
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        logic w_prev;
        if (g == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_body
            assign w_prev = w_pm[g-1];
        end
        wbps_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_prev_pm (w_prev),
            .o_pm      (w_pm[g]),
            .o_tail    (w_tail[g])
        );
    end

    // byte offset in the region, wraps modulo 2^64
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (w_scan_acc) begin
            r_offset <= s_axis_tlast ? '0 : r_offset + ADDR_W'(1);
        end
    end

    // -----------------------------------------------------------------------
    // stage after the row: match flag and candidate start address
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_free) begin
            r_s1.valid <= w_scan_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_s1.tail <= |w_tail;
            r_s1.last <= s_axis_tlast;
            // start of a match ending at this byte
            r_s1.addr <= r_base + r_offset - ADDR_W'(w_len_c) + ADDR_W'(1);
        end
    end

    // -----------------------------------------------------------------------
    // accumulator and result register
    // -----------------------------------------------------------------------
    wbps_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (r_s1),
        .i_m_ready (m_axis_tready),
        .o_free    (w_free),
        .o_m_valid (m_axis_tvalid),
        .o_count   (w_count),
        .o_found   (w_found),
        .o_unique  (w_unique)
    );

    assign m_axis_tdata = {7'b0, w_unique, w_found, w_count};

    `WBPS_ASSERT(a_offset_clear, (w_scan_acc && s_axis_tlast) |=> (r_offset == '0), "byte offset not cleared after region end")

endmodule
